### rtl/owts_pkg.sv
// shared types, codes and sequence tables for the single-wire temperature master
// used by owts_front, owts_back and the top level
package owts_pkg;

  localparam int CFG_W          = 17;
  localparam int CFG_IDX_W      = 3;
  localparam int TIMER_BITS_DEF = 17;
  localparam int Q_DEPTH        = 2;
  localparam int Q_PTR_W        = 1;
  localparam int Q_CNT_W        = 2;
  localparam int TEMP_OPS       = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_RELEASE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_SHORT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_LONG     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_READ_RECOVERY = 3'd7;

  localparam logic [7:0] ROM_SKIP   = 8'hcc;
  localparam logic [7:0] CONVERT_T  = 8'h44;
  localparam logic [7:0] READ_SCRATCH = 8'hbe;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_RESET = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_READ  = 3'd3,
    CMD_TEMP  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    OP_RESET = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_RST_LOW   = 4'd1,
    PH_RST_REL   = 4'd2,
    PH_PRES_WAIT = 4'd3,
    PH_PRES_LOW  = 4'd4,
    PH_WR_LOW    = 4'd5,
    PH_WR_HIGH   = 4'd6,
    PH_RD_LOW    = 4'd7,
    PH_RD_WAIT   = 4'd8,
    PH_RD_REC    = 4'd9
  } phase_t;

  // one tick as it sits in the queue
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] write_byte;
    logic       line_level;
  } tick_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] shift;
  } op_start_t;

  function automatic op_t temp_op(input logic [2:0] step);
    op_t k;
    unique case (step)
      3'd0, 3'd3: k = OP_RESET;
      3'd6, 3'd7: k = OP_READ;
      default:    k = OP_WRITE;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] temp_byte(input logic [2:0] step);
    logic [7:0] b;
    unique case (step)
      3'd1, 3'd4: b = ROM_SKIP;
      3'd2:       b = CONVERT_T;
      3'd5:       b = READ_SCRATCH;
      default:    b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic op_t op_kind(input cmd_t ac, input logic [2:0] step);
    op_t k;
    unique case (ac)
      CMD_TEMP:  k = temp_op(step);
      CMD_WRITE: k = OP_WRITE;
      CMD_READ:  k = OP_READ;
      default:   k = OP_RESET;
    endcase
    return k;
  endfunction

endpackage

### rtl/owts_front.sv
// input side: classifies the command of each tick and holds ticks in a short queue
// depends on owts_pkg
module owts_front
  import owts_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] cmd,
  input  logic [7:0] write_byte,
  input  logic       line_level,
  output logic       q_valid,
  output tick_t      q_tick,
  input  logic       q_pop
);

  tick_t              entry [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               push;
  tick_t              tick_in;
  cmd_t               cmd_class;

  // undefined command codes act as no command
  always_comb begin
    unique case (cmd) inside
      CMD_RESET, CMD_WRITE, CMD_READ, CMD_TEMP: cmd_class = cmd_t'(cmd);
      default: cmd_class = CMD_NONE;
    endcase
  end

  assign tick_in  = '{cmd: cmd_class, write_byte: write_byte, line_level: line_level};
  assign in_stall = (count == Q_CNT_W'(Q_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign q_tick   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= tick_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/owts_back.sv
// bus engine: runs the reset, write, read and temperature sequences one tick per cycle
// while no result is stalled; holds timing and result registers; depends on owts_pkg
module owts_back
  import owts_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 q_valid,
  input  tick_t                q_tick,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 drive_low,
  output logic                 busy_res,
  output logic                 done_res,
  output logic                 no_device,
  output logic [7:0]           read_byte,
  output logic signed [15:0]   temperature
);

  localparam int CW = ((TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W) + 1;
  localparam logic [CW-1:0] TMAX = CW'((64'd1 << TIMER_BITS) - 64'd1);

  // timing registers
  logic [11:0] reset_low_us;
  logic [7:0]  reset_release_us;
  logic [16:0] presence_wait_us;
  logic [9:0]  presence_low_max_us;
  logic [5:0]  slot_short_us;
  logic [7:0]  slot_long_us;
  logic [5:0]  read_sample_us;
  logic [7:0]  read_recovery_us;

  // engine state
  phase_t                phase, phase_next;
  logic [TIMER_BITS-1:0] timer, timer_next;
  logic [2:0]            bit_idx, bit_idx_next;
  logic [7:0]            shift, shift_next;
  logic [2:0]            step, step_next;
  logic [7:0]            low_hold, low_hold_next;
  cmd_t                  act, act_next;
  logic                  pres_fail, pres_fail_next;
  logic [15:0]           temp_hold, temp_hold_next;
  logic [7:0]            wlatch, wlatch_next;
  logic [7:0]            last_read, last_read_next;
  logic                  drive, done;

  function automatic op_start_t begin_op(input cmd_t ac, input logic [2:0] st,
                                         input logic [7:0] wl, input logic [7:0] sh);
    op_start_t r;
    r.shift = sh;
    unique case (op_kind(ac, st))
      OP_RESET: r.phase = PH_RST_LOW;
      OP_WRITE: begin
        r.phase = PH_WR_LOW;
        r.shift = (ac == CMD_TEMP) ? temp_byte(st) : wl;
      end
      default: begin
        r.phase = PH_RD_LOW;
        r.shift = 8'h00;
      end
    endcase
    return r;
  endfunction

  assign q_pop = q_valid && (!out_valid || !out_stall);

  always_comb begin : engine
    op_start_t      bo;
    logic           bit_now;
    logic           fin;
    logic [CFG_W-1:0] d_sel;
    logic [CW-1:0]  d_eff;
    logic           tick_end;
    logic [3:0]     step_inc;
    phase_t         phase_run;

    phase_next     = phase;
    timer_next     = timer;
    bit_idx_next   = bit_idx;
    shift_next     = shift;
    step_next      = step;
    low_hold_next  = low_hold;
    act_next       = act;
    pres_fail_next = pres_fail;
    temp_hold_next = temp_hold;
    wlatch_next    = wlatch;
    last_read_next = last_read;
    drive          = 1'b0;
    fin            = 1'b0;
    done           = 1'b0;
    bo             = '0;

    // command start: bus activity begins on the same tick
    if (phase == PH_IDLE && q_tick.cmd != CMD_NONE) begin
      act_next    = q_tick.cmd;
      wlatch_next = q_tick.write_byte;
      step_next   = '0;
      bo          = begin_op(q_tick.cmd, 3'd0, q_tick.write_byte, shift);
      phase_next  = bo.phase;
      shift_next  = bo.shift;
      timer_next  = '0;
      bit_idx_next = '0;
    end
    bit_now   = shift_next[0];
    phase_run = phase_next;

    unique case (phase_next)
      PH_RST_LOW:   d_sel = CFG_W'(reset_low_us);
      PH_RST_REL:   d_sel = CFG_W'(reset_release_us);
      PH_PRES_WAIT: d_sel = presence_wait_us;
      PH_PRES_LOW:  d_sel = CFG_W'(presence_low_max_us);
      PH_WR_LOW:    d_sel = bit_now ? CFG_W'(slot_short_us) : CFG_W'(slot_long_us);
      PH_WR_HIGH:   d_sel = bit_now ? CFG_W'(slot_long_us) : CFG_W'(slot_short_us);
      PH_RD_LOW:    d_sel = CFG_W'(slot_short_us);
      PH_RD_WAIT:   d_sel = CFG_W'(read_sample_us);
      PH_RD_REC:    d_sel = CFG_W'(read_recovery_us);
      default:      d_sel = '0;
    endcase

    // zero acts as one tick, long values clip to the timer range
    d_eff = (d_sel == '0) ? CW'(1) : CW'(d_sel);
    if (d_eff > TMAX) begin
      d_eff = TMAX;
    end
    tick_end = (CW'(timer_next) + CW'(1)) >= d_eff;

    unique case (phase_next)
      PH_IDLE: begin
      end
      PH_RST_LOW: begin
        drive = 1'b1;
        if (tick_end) phase_next = PH_RST_REL;
      end
      PH_RST_REL: begin
        if (tick_end) phase_next = PH_PRES_WAIT;
      end
      PH_PRES_WAIT: begin
        if (!q_tick.line_level) begin
          phase_next = PH_PRES_LOW;
        end else if (tick_end) begin
          pres_fail_next = 1'b1;
          fin = 1'b1;
        end
      end
      PH_PRES_LOW: begin
        if (q_tick.line_level) begin
          pres_fail_next = 1'b0;
          fin = 1'b1;
        end else if (tick_end) begin
          pres_fail_next = 1'b1;
          fin = 1'b1;
        end
      end
      PH_WR_LOW: begin
        drive = 1'b1;
        if (tick_end) phase_next = PH_WR_HIGH;
      end
      PH_WR_HIGH: begin
        if (tick_end) begin
          shift_next = {1'b0, shift_next[7:1]};
          if (bit_idx_next == 3'd7) fin = 1'b1;
          else begin
            bit_idx_next = bit_idx_next + 1'b1;
            phase_next = PH_WR_LOW;
          end
        end
      end
      PH_RD_LOW: begin
        drive = 1'b1;
        if (tick_end) phase_next = PH_RD_WAIT;
      end
      PH_RD_WAIT: begin
        if (tick_end) begin
          shift_next = {q_tick.line_level, shift_next[7:1]};
          phase_next = PH_RD_REC;
        end
      end
      PH_RD_REC: begin
        if (tick_end) begin
          if (bit_idx_next == 3'd7) fin = 1'b1;
          else begin
            bit_idx_next = bit_idx_next + 1'b1;
            phase_next = PH_RD_LOW;
          end
        end
      end
      default: phase_next = PH_IDLE;
    endcase

    // timer update for the phases that ran an interval this tick
    if (phase_next != phase_run || tick_end || fin) begin
      timer_next = '0;
    end else begin
      timer_next = timer_next + 1'b1;
    end
    if (phase_next == PH_IDLE) begin
      timer_next = timer_next;
    end

    if (fin) begin
      if (op_kind(act_next, step_next) == OP_READ) begin
        last_read_next = shift_next;
        if (act_next == CMD_TEMP) begin
          if (step_next == 3'd6) low_hold_next = shift_next;
          else temp_hold_next = {shift_next, low_hold_next};
        end
      end
      step_inc = {1'b0, step_next} + 4'd1;
      if (step_inc >= ((act_next == CMD_TEMP) ? 4'(TEMP_OPS) : 4'd1)) begin
        phase_next = PH_IDLE;
        timer_next = '0;
        step_next  = '0;
        done       = 1'b1;
      end else begin
        step_next    = step_inc[2:0];
        bo           = begin_op(act_next, step_next, wlatch_next, shift_next);
        phase_next   = bo.phase;
        shift_next   = bo.shift;
        timer_next   = '0;
        bit_idx_next = '0;
      end
    end else begin
      step_inc = {1'b0, step_next};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reset_low_us        <= 12'd750;
      reset_release_us    <= 8'd15;
      presence_wait_us    <= 17'd100000;
      presence_low_max_us <= 10'd240;
      slot_short_us       <= 6'd2;
      slot_long_us        <= 8'd60;
      read_sample_us      <= 6'd12;
      read_recovery_us    <= 8'd50;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RESET_LOW:     reset_low_us        <= cfg_data[11:0];
        REG_RESET_RELEASE: reset_release_us    <= cfg_data[7:0];
        REG_PRESENCE_WAIT: presence_wait_us    <= cfg_data;
        REG_PRESENCE_LOW:  presence_low_max_us <= cfg_data[9:0];
        REG_SLOT_SHORT:    slot_short_us       <= cfg_data[5:0];
        REG_SLOT_LONG:     slot_long_us        <= cfg_data[7:0];
        REG_READ_SAMPLE:   read_sample_us      <= cfg_data[5:0];
        REG_READ_RECOVERY: read_recovery_us    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      timer     <= '0;
      bit_idx   <= '0;
      shift     <= '0;
      step      <= '0;
      low_hold  <= '0;
      act       <= CMD_NONE;
      pres_fail <= 1'b0;
      temp_hold <= '0;
      wlatch    <= '0;
      last_read <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= q_pop || (out_valid && out_stall);
      if (q_pop) begin
        phase     <= phase_next;
        timer     <= timer_next;
        bit_idx   <= bit_idx_next;
        shift     <= shift_next;
        step      <= step_next;
        low_hold  <= low_hold_next;
        act       <= act_next;
        pres_fail <= pres_fail_next;
        temp_hold <= temp_hold_next;
        wlatch    <= wlatch_next;
        last_read <= last_read_next;
      end
    end
  end

  // result register for the tick just processed
  always_ff @(posedge clk) begin
    if (q_pop) begin
      drive_low   <= drive;
      busy_res    <= (phase_next != PH_IDLE);
      done_res    <= done;
      no_device   <= pres_fail_next;
      read_byte   <= last_read_next;
      temperature <= temp_hold_next;
    end
  end

endmodule

### rtl/one_wire_temp_sensor_master.sv
// Single-wire bus master for a temperature sensor. Each input transfer is one
// microsecond tick carrying the sampled line level and an optional command (bus
// reset, write byte, read byte, full temperature read); each tick yields exactly
// one result transfer with the line drive and status for that tick. Ticks are
// taken at one per clock cycle while in_stall is low: a two-entry queue sits in
// front of the bus engine, the engine handles one tick per cycle while no result
// waits, and a result register holds each result until it is taken. Timing
// registers must be written through the cfg port only while no command is running;
// the block does not enforce this. Temperature is in sixteenths of a degree.
module one_wire_temp_sensor_master
  import owts_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           cmd,
  input  logic [7:0]           write_byte,
  input  logic                 line_level,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 drive_low,
  output logic                 busy_res,
  output logic                 done_res,
  output logic                 no_device,
  output logic [7:0]           read_byte,
  output logic signed [15:0]   temperature
);

  logic  q_valid;
  logic  q_pop;
  tick_t q_tick;

  owts_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .write_byte (write_byte),
    .line_level (line_level),
    .q_valid    (q_valid),
    .q_tick     (q_tick),
    .q_pop      (q_pop)
  );

  owts_back #(
    .TIMER_BITS (TIMER_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_valid     (q_valid),
    .q_tick      (q_tick),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .drive_low   (drive_low),
    .busy_res    (busy_res),
    .done_res    (done_res),
    .no_device   (no_device),
    .read_byte   (read_byte),
    .temperature (temperature)
  );

endmodule
